// File: src/sparse_polynomial_add_unit_assert.svh
// ----------------------------------------------------------------------------
// sparse polynomial add unit assertion macros
// shared property forms for the unit's concurrent checks
// ----------------------------------------------------------------------------
`ifndef SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH
`define SPARSE_POLYNOMIAL_ADD_UNIT_ASSERT_SVH

// same-cycle implication
`define SPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("spa assertion failed");

// next-cycle implication
`define SPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("spa assertion failed");

`endif

// File: src/spa_pkg.sv
// ----------------------------------------------------------------------------
// spa_pkg
// widths, term and command types of the sparse polynomial add unit
// ----------------------------------------------------------------------------
package spa_pkg;

   localparam int MAX_TERMS     = 32;
   localparam int COEFF_BITS    = 16;
   localparam int POWER_BITS    = 8;
   localparam int SUM_BITS      = COEFF_BITS + 1;
   localparam int ADDR_BITS     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int COUNT_BITS    = $clog2(MAX_TERMS + 1);
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   // what the back end has to do with one request
   typedef enum logic [1:0] {
      CMD_FIRST  = 2'd0,   // store into first list
      CMD_SECOND = 2'd1,   // store into second list
      CMD_MERGE  = 2'd2    // store into second list, then merge
   } cmd_kind_type;

   typedef struct packed {
      logic signed [COEFF_BITS-1:0] coeff;
      logic [POWER_BITS-1:0]        power;
   } term_type;

   typedef struct packed {
      cmd_kind_type kind;
      term_type     term;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

endpackage

// File: src/spa_if.sv
// ----------------------------------------------------------------------------
// spa channel interfaces
// request and response channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface spa_req_if;
   logic                                valid;
   logic                                ready;
   logic                                second_poly;
   logic signed [spa_pkg::COEFF_BITS-1:0] in_coeff;
   logic [spa_pkg::POWER_BITS-1:0]      in_power;
   logic                                end_of_poly;

   modport source (output valid, second_poly, in_coeff, in_power, end_of_poly,
                   input ready);
   modport sink (input valid, second_poly, in_coeff, in_power, end_of_poly,
                 output ready);
endinterface

interface spa_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spa_pkg::SUM_BITS-1:0] out_coeff;
   logic [spa_pkg::POWER_BITS-1:0]      out_power;
   logic                                last_term;
   logic                                dropped_terms;

   modport source (output valid, out_coeff, out_power, last_term, dropped_terms,
                   input ready);
   modport sink (input valid, out_coeff, out_power, last_term, dropped_terms,
                 output ready);
endinterface

// File: src/spa_front.sv
// ----------------------------------------------------------------------------
// spa_front
// accepts requests and classifies them into back end commands
// ----------------------------------------------------------------------------
module spa_front (
   spa_req_if.sink                req,
   input  spa_pkg::fifo_stat_type stat,
   output logic                   push,
   output spa_pkg::cmd_type       cmd
);

   assign req.ready = !stat.full;
   assign push      = req.valid && !stat.full;

   always_comb begin
      cmd.term.coeff = req.in_coeff;
      cmd.term.power = req.in_power;
      priority if (!req.second_poly) begin
         cmd.kind = spa_pkg::CMD_FIRST;
      end else if (req.end_of_poly) begin
         cmd.kind = spa_pkg::CMD_MERGE;
      end else begin
         cmd.kind = spa_pkg::CMD_SECOND;
      end
   end

endmodule

// File: src/spa_cmd_fifo.sv
// ----------------------------------------------------------------------------
// spa_cmd_fifo
// short command queue between front and back end
// ----------------------------------------------------------------------------
module spa_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  spa_pkg::cmd_type       push_cmd,
   input  logic                   pop,
   output spa_pkg::cmd_type       head_cmd,
   output spa_pkg::fifo_stat_type stat
);

   spa_pkg::cmd_type                   slot_ff [spa_pkg::FIFO_DEPTH];
   logic [spa_pkg::FIFO_PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [spa_pkg::FIFO_PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [spa_pkg::FIFO_CNT_BITS-1:0]  count_ff, count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == spa_pkg::FIFO_CNT_BITS'(spa_pkg::FIFO_DEPTH));
   assign head_cmd   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: src/spa_back.sv
// ----------------------------------------------------------------------------
// spa_back
// term stores and merge engine with the response register
// ----------------------------------------------------------------------------
module spa_back (
   input  logic                   clock,
   input  logic                   reset,
   input  spa_pkg::cmd_type       cmd,
   input  spa_pkg::fifo_stat_type stat,
   output logic                   pop,
   spa_rsp_if.source              rsp
);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_PRIME = 3'b010,
      ST_MERGE = 3'b100
   } state_type;

   localparam int AW = spa_pkg::ADDR_BITS;
   localparam int CW = spa_pkg::COUNT_BITS;
   localparam int SW = spa_pkg::SUM_BITS;
   localparam int KW = spa_pkg::COEFF_BITS;

   state_type                 state_ff, state_in;
   logic [CW-1:0]             first_count_ff, first_count_in;
   logic [CW-1:0]             second_count_ff, second_count_in;
   logic [CW-1:0]             i_ff, i_in;
   logic [CW-1:0]             j_ff, j_in;
   logic                      overflow_ff, overflow_in;

   spa_pkg::term_type         first_terms_ff [spa_pkg::MAX_TERMS];
   spa_pkg::term_type         second_terms_ff [spa_pkg::MAX_TERMS];
   spa_pkg::term_type         first_rd_ff, second_rd_ff;
   logic                      first_wr, second_wr;

   logic                      out_valid_ff, out_valid_in;
   logic signed [SW-1:0]      out_coeff_ff, out_coeff_in;
   logic [spa_pkg::POWER_BITS-1:0] out_power_ff, out_power_in;
   logic                      out_last_ff, out_last_in;
   logic                      out_drop_ff, out_drop_in;

   logic                      first_ok, second_ok, out_free, emit;
   logic                      take_first, take_second;
   logic                      first_room, second_room;
   logic signed [SW-1:0]      first_ext, second_ext;

   assign first_ok    = (i_ff < first_count_ff);
   assign second_ok   = (j_ff < second_count_ff);
   assign out_free    = !out_valid_ff || rsp.ready;
   assign pop         = (state_ff == ST_IDLE) && !stat.empty;
   assign first_room  = (first_count_ff < CW'(spa_pkg::MAX_TERMS));
   assign second_room = (second_count_ff < CW'(spa_pkg::MAX_TERMS));
   assign first_wr    = pop && (cmd.kind == spa_pkg::CMD_FIRST) && first_room;
   assign second_wr   = pop && (cmd.kind != spa_pkg::CMD_FIRST) && second_room;
   assign first_ext   = {first_rd_ff.coeff[KW-1], first_rd_ff.coeff};
   assign second_ext  = {second_rd_ff.coeff[KW-1], second_rd_ff.coeff};

   always_comb begin
      take_first  = 1'b0;
      take_second = 1'b0;
      unique case ({first_ok, second_ok})
         2'b11: begin
            take_first  = (first_rd_ff.power >= second_rd_ff.power);
            take_second = (first_rd_ff.power <= second_rd_ff.power);
         end
         2'b10:   take_first = 1'b1;
         2'b01:   take_second = 1'b1;
         default: ;
      endcase
   end

   assign emit = (state_ff == ST_MERGE) && out_free && (first_ok || second_ok);

   always_comb begin
      state_in        = state_ff;
      first_count_in  = first_count_ff;
      second_count_in = second_count_ff;
      overflow_in     = overflow_ff;
      i_in            = i_ff;
      j_in            = j_ff;
      out_valid_in    = out_valid_ff && !rsp.ready;
      out_coeff_in    = out_coeff_ff;
      out_power_in    = out_power_ff;
      out_last_in     = out_last_ff;
      out_drop_in     = out_drop_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               if (cmd.kind == spa_pkg::CMD_FIRST) begin
                  if (first_room) begin
                     first_count_in = first_count_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end else begin
                  if (second_room) begin
                     second_count_in = second_count_ff + 1'b1;
                  end else begin
                     overflow_in = 1'b1;
                  end
               end
               if (cmd.kind == spa_pkg::CMD_MERGE) begin
                  state_in = ST_PRIME;
               end
            end
         end
         ST_PRIME: begin
            // the read registers load the list heads as this state ends
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (emit) begin
               if (take_first) begin
                  i_in = i_ff + 1'b1;
               end
               if (take_second) begin
                  j_in = j_ff + 1'b1;
               end
               out_valid_in = 1'b1;
               out_drop_in  = overflow_ff;
               unique case ({take_first, take_second})
                  2'b11: begin
                     out_coeff_in = first_ext + second_ext;
                     out_power_in = first_rd_ff.power;
                  end
                  2'b10: begin
                     out_coeff_in = first_ext;
                     out_power_in = first_rd_ff.power;
                  end
                  default: begin
                     out_coeff_in = second_ext;
                     out_power_in = second_rd_ff.power;
                  end
               endcase
               out_last_in = (i_in >= first_count_ff) && (j_in >= second_count_ff);
            end
            if ((emit && out_last_in) || (!first_ok && !second_ok)) begin
               state_in        = ST_IDLE;
               first_count_in  = '0;
               second_count_in = '0;
               overflow_in     = 1'b0;
               i_in            = '0;
               j_in            = '0;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
         i_ff            <= '0;
         j_ff            <= '0;
         out_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         first_count_ff  <= first_count_in;
         second_count_ff <= second_count_in;
         overflow_ff     <= overflow_in;
         i_ff            <= i_in;
         j_ff            <= j_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_coeff_ff <= out_coeff_in;
      out_power_ff <= out_power_in;
      out_last_ff  <= out_last_in;
      out_drop_ff  <= out_drop_in;
   end

   // term stores, one write and one registered read each
   always_ff @(posedge clock) begin
      if (first_wr) begin
         first_terms_ff[first_count_ff[AW-1:0]] <= cmd.term;
      end
      first_rd_ff <= first_terms_ff[i_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (second_wr) begin
         second_terms_ff[second_count_ff[AW-1:0]] <= cmd.term;
      end
      second_rd_ff <= second_terms_ff[j_in[AW-1:0]];
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_coeff     = out_coeff_ff;
   assign rsp.out_power     = out_power_ff;
   assign rsp.last_term     = out_last_ff;
   assign rsp.dropped_terms = out_drop_ff;

endmodule

// File: src/sparse_polynomial_add_unit.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_add_unit
// adds two sparse polynomials given as descending-power term lists
// ----------------------------------------------------------------------------
//  channel   direction  handshake      payload
//  req_ch    in         valid / ready  second_poly, in_coeff, in_power, end_of_poly
//  rsp_ch    out        valid / ready  out_coeff, out_power, last_term, dropped_terms
//
//  a request is stored into its term list once the idle back end takes it from the queue
//  a final second-list request starts the merge: the prime state reads the list heads,
//  then the merge state gives one result term a cycle unless the response is stalled
//  the command queue holds four requests, so the front keeps taking requests
//  while a merge runs; it stalls only when the queue is full
//  a stalled response holds in the output register and freezes the merge
//  synchronous reset empties both lists and the queue; term stores need no clearing
// ----------------------------------------------------------------------------
`include "sparse_polynomial_add_unit_assert.svh"

module sparse_polynomial_add_unit (
   input  logic       clock,
   input  logic       reset,
   spa_req_if.sink    req_ch,
   spa_rsp_if.source  rsp_ch
);

   // front to queue
   logic                   push;
   spa_pkg::cmd_type       push_cmd;

   // queue to back end
   logic                   pop;
   spa_pkg::cmd_type       head_cmd;
   spa_pkg::fifo_stat_type stat;

   // request classification
   spa_front u_front (
      .req  (req_ch),
      .stat (stat),
      .push (push),
      .cmd  (push_cmd)
   );

   // decoupling queue
   spa_cmd_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .stat     (stat)
   );

   // list stores and merge
   spa_back u_back (
      .clock (clock),
      .reset (reset),
      .cmd   (head_cmd),
      .stat  (stat),
      .pop   (pop),
      .rsp   (rsp_ch)
   );

   // no write into a full queue, no read from an empty one
   `SPA_ASSERT_NOW(a_no_push_full, clock, reset, push, !stat.full)
   `SPA_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, !stat.empty)
   // a stalled response stays offered and unchanged
   `SPA_ASSERT_NEXT(a_rsp_hold_valid, clock, reset, rsp_ch.valid && !rsp_ch.ready, rsp_ch.valid)
   `SPA_ASSERT_NEXT(a_rsp_hold_data, clock, reset, rsp_ch.valid && !rsp_ch.ready, $stable(rsp_ch.out_coeff) && $stable(rsp_ch.out_power) && $stable(rsp_ch.last_term))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// checks the sparse polynomial add unit: term requests go in over a
// valid / ready channel, every merged term coming back is compared against
// a term-list merge computed in the testbench at request acceptance
// ----------------------------------------------------------------------------
module tb_top;

   localparam int POWER_SPAN  = 1 << spa_pkg::POWER_BITS;
   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_WAIT  = 2 * spa_pkg::MAX_TERMS + 16;

   typedef logic signed [spa_pkg::COEFF_BITS-1:0] coeff_type;
   typedef logic [spa_pkg::POWER_BITS-1:0]        power_type;

   // one term request as the sender offers it
   typedef struct {
      logic              second;
      spa_pkg::term_type term;
      logic              last;
   } term_req_type;

   // one merged term as the block should return it
   typedef struct {
      logic signed [spa_pkg::SUM_BITS-1:0] coeff;
      power_type                           power;
      logic                                last;
      logic                                dropped;
   } sum_term_type;

   logic clock = 1'b0;
   logic reset;

   spa_req_if req_ch ();
   spa_rsp_if rsp_ch ();

   sparse_polynomial_add_unit u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #5 clock = ~clock;

   // stimulus and expectations
   term_req_type pending_terms[$];
   sum_term_type due_terms[$];
   term_req_type cur_term;
   term_req_type next_term;

   // local copy of the block's term stores
   spa_pkg::term_type first_list [spa_pkg::MAX_TERMS];
   spa_pkg::term_type second_list[spa_pkg::MAX_TERMS];
   int                first_len     = 0;
   int                second_len    = 0;
   logic              overflow_flag = 1'b0;

   // idling knobs, percent of cycles
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;

   // long receiver hold-off, requested by count and served by its own process
   int hold_req    = 0;
   int hold_served = 0;
   int hold_left   = 0;

   int error_count = 0;
   int cycle_count = 0;

   // ------------------------------------------------------------------------
   // term-list merge, run once per accepted request
   // ------------------------------------------------------------------------
   function automatic void predict_sum(input term_req_type t);
      sum_term_type merged[$];
      sum_term_type r;
      int           i;
      int           j;
      if (!t.second) begin
         // first-list term, also when it comes after second terms began
         if (first_len < spa_pkg::MAX_TERMS) begin
            first_list[first_len] = t.term;
            first_len++;
         end else begin
            overflow_flag = 1'b1;
         end
         return;
      end
      if (second_len < spa_pkg::MAX_TERMS) begin
         second_list[second_len] = t.term;
         second_len++;
      end else begin
         overflow_flag = 1'b1;
      end
      // full store still honors the final mark
      if (!t.last) return;

      i = 0;
      j = 0;
      while (i < first_len || j < second_len) begin
         r.dropped = overflow_flag;
         r.last    = 1'b0;
         if (j >= second_len ||
             (i < first_len && first_list[i].power > second_list[j].power)) begin
            r.coeff = $signed(first_list[i].coeff);
            r.power = first_list[i].power;
            i++;
         end else if (i >= first_len || first_list[i].power < second_list[j].power) begin
            r.coeff = $signed(second_list[j].coeff);
            r.power = second_list[j].power;
            j++;
         end else begin
            // matched powers: one term with the sum, zero sums included
            r.coeff = $signed(first_list[i].coeff) + $signed(second_list[j].coeff);
            r.power = first_list[i].power;
            i++;
            j++;
         end
         merged.push_back(r);
      end
      if (merged.size() != 0) merged[merged.size()-1].last = 1'b1;
      foreach (merged[k]) due_terms.push_back(merged[k]);

      // a new pair of polynomials starts after the merge
      first_len     = 0;
      second_len    = 0;
      overflow_flag = 1'b0;
   endfunction

   function automatic void push_term(input logic second, input coeff_type c,
                                     input power_type p, input logic eop);
      term_req_type t;
      t.second     = second;
      t.term.coeff = c;
      t.term.power = p;
      t.last       = eop;
      pending_terms.push_back(t);
   endfunction

   function automatic coeff_type rand_coeff();
      case ($urandom_range(9, 0))
         0:       return {1'b0, {(spa_pkg::COEFF_BITS-1){1'b1}}};
         1:       return {1'b1, {(spa_pkg::COEFF_BITS-1){1'b0}}};
         2:       return '0;
         3:       return '1;
         default: return coeff_type'($urandom);
      endcase
   endfunction

   // one random pair of polynomials, returns the number of requests queued
   function automatic int add_random_pair();
      bit [POWER_SPAN-1:0] in_first;
      bit [POWER_SPAN-1:0] in_second;
      coeff_type           coeff_at[POWER_SPAN];
      power_type           fp[$];
      power_type           sp[$];
      coeff_type           c;
      int                  kind;
      int                  nf;
      int                  ns;
      int                  n;
      int                  q;
      int                  split;
      kind      = $urandom_range(99, 0);
      in_first  = '0;
      in_second = '0;
      if (kind >= 85) begin
         // noise: powers in any order, repeats allowed
         nf = $urandom_range(6, 0);
         ns = $urandom_range(6, 1);
         for (n = 0; n < nf; n++)
            fp.push_back(power_type'($urandom_range(POWER_SPAN-1, 0)));
         for (n = 0; n < ns; n++)
            sp.push_back(power_type'($urandom_range(POWER_SPAN-1, 0)));
      end else begin
         // well formed: distinct descending powers, second list often
         // reusing powers of the first so terms get summed
         nf = $urandom_range(8, 0);
         ns = $urandom_range(8, 1);
         for (n = 0; n < nf; n++) in_first[$urandom_range(POWER_SPAN-1, 0)] = 1'b1;
         for (q = POWER_SPAN-1; q >= 0; q--) if (in_first[q]) fp.push_back(power_type'(q));
         for (n = 0; n < ns; n++) begin
            if (fp.size() != 0 && $urandom_range(1, 0) == 1)
               in_second[fp[$urandom_range(fp.size()-1, 0)]] = 1'b1;
            else
               in_second[$urandom_range(POWER_SPAN-1, 0)] = 1'b1;
         end
         for (q = POWER_SPAN-1; q >= 0; q--) if (in_second[q]) sp.push_back(power_type'(q));
      end

      // some pairs send part of the first list after second terms began
      split = (kind >= 70 && kind < 85) ? $urandom_range(fp.size(), 0) : fp.size();

      for (n = 0; n < fp.size(); n++) coeff_at[fp[n]] = rand_coeff();
      for (n = 0; n < split; n++)
         push_term(1'b0, coeff_at[fp[n]], fp[n],
                   (n == fp.size()-1) ? ($urandom_range(3, 0) != 0)
                                      : ($urandom_range(9, 0) == 0));
      for (n = 0; n < sp.size(); n++) begin
         if (n == sp.size()-1) begin
            for (q = split; q < fp.size(); q++)
               push_term(1'b0, coeff_at[fp[q]], fp[q], $urandom_range(1, 0));
         end
         // now and then cancel a matched term to a zero sum
         c = (in_first[sp[n]] && $urandom_range(3, 0) == 0) ? -coeff_at[sp[n]]
                                                            : rand_coeff();
         push_term(1'b1, c, sp[n], n == sp.size()-1);
      end
      return fp.size() + sp.size();
   endfunction

   task automatic wait_drained();
      while (pending_terms.size() != 0) @(negedge clock);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct,
                            input int target, input bit with_hold);
      int queued;
      queued = 0;
      @(negedge clock);
      send_idle_pct  <= send_pct;
      recv_stall_pct <= recv_pct;
      if (with_hold) hold_req <= hold_req + 1;
      while (queued < target) queued += add_random_pair();
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // request driver: offers the next queued term, predicts on acceptance
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) predict_sum(cur_term);
         if (!req_ch.valid || req_ch.ready) begin
            if (pending_terms.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               next_term           = pending_terms.pop_front();
               cur_term           <= next_term;
               req_ch.second_poly <= next_term.second;
               req_ch.in_coeff    <= next_term.term.coeff;
               req_ch.in_power    <= next_term.term.power;
               req_ch.end_of_poly <= next_term.last;
               req_ch.valid       <= 1'b1;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // long hold-off of the receiver, the block must fill and stall requests
   always @(posedge clock) begin
      if (reset) begin
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_req) begin
         hold_served <= hold_req;
         hold_left   <= HOLD_CYCLES;
      end
   end

   // ------------------------------------------------------------------------
   // response monitor: checks each accepted term against the oldest expected
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (due_terms.size() == 0) begin
               $error("unexpected term: coeff %0d power %0d", rsp_ch.out_coeff,
                      rsp_ch.out_power);
               error_count++;
            end else begin
               if (rsp_ch.out_coeff !== due_terms[0].coeff) begin
                  $error("out_coeff: expected %0d, got %0d", due_terms[0].coeff,
                         rsp_ch.out_coeff);
                  error_count++;
               end
               if (rsp_ch.out_power !== due_terms[0].power) begin
                  $error("out_power: expected %0d, got %0d", due_terms[0].power,
                         rsp_ch.out_power);
                  error_count++;
               end
               if (rsp_ch.last_term !== due_terms[0].last) begin
                  $error("last_term: expected %0b, got %0b", due_terms[0].last,
                         rsp_ch.last_term);
                  error_count++;
               end
               if (rsp_ch.dropped_terms !== due_terms[0].dropped) begin
                  $error("dropped_terms: expected %0b, got %0b", due_terms[0].dropped,
                         rsp_ch.dropped_terms);
                  error_count++;
               end
               void'(due_terms.pop_front());
            end
         end
         rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------
   initial begin
      int p;
      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.second_poly = 1'b0;
      req_ch.in_coeff    = '0;
      req_ch.in_power    = '0;
      req_ch.end_of_poly = 1'b0;
      rsp_ch.ready       = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // coefficient extremes on matched powers, zero sum, power extremes
      push_term(1'b0, 16'sh7fff, 8'd255, 1'b0);
      push_term(1'b0, 16'sh8000, 8'd128, 1'b0);
      push_term(1'b0, 16'sd5,    8'd0,   1'b1);
      push_term(1'b1, 16'sh7fff, 8'd255, 1'b0);
      push_term(1'b1, 16'sh8000, 8'd128, 1'b0);
      push_term(1'b1, -16'sd5,   8'd0,   1'b1);

      // interleaved unmatched terms, a stray end mark mid first list,
      // a first-list term arriving after second terms began
      push_term(1'b0, 16'sd100,  8'd200, 1'b1);
      push_term(1'b0, -16'sd1,   8'd50,  1'b0);
      push_term(1'b1, 16'sd7,    8'd220, 1'b0);
      push_term(1'b1, 16'sd3,    8'd60,  1'b0);
      push_term(1'b0, 16'sd9,    8'd10,  1'b0);
      push_term(1'b1, 16'sd4,    8'd5,   1'b1);

      // powers not descending
      push_term(1'b0, 16'sd1,    8'd3,   1'b0);
      push_term(1'b0, 16'sd2,    8'd9,   1'b1);
      push_term(1'b1, 16'sd3,    8'd9,   1'b0);
      push_term(1'b1, 16'sd4,    8'd3,   1'b1);

      // empty first list
      push_term(1'b1, -16'sd7,   8'd17,  1'b0);
      push_term(1'b1, 16'sh5a5a, 8'hd2,  1'b1);

      // single first term, longer second tail
      push_term(1'b0, 16'sd0,    8'd0,   1'b1);
      push_term(1'b1, 16'sd1,    8'd255, 1'b0);
      push_term(1'b1, 16'sha5a5, 8'd254, 1'b0);
      push_term(1'b1, 16'sd3,    8'd0,   1'b1);

      // both stores overrun: extra terms dropped, flag on every result
      for (p = 0; p < spa_pkg::MAX_TERMS + 2; p++)
         push_term(1'b0, rand_coeff(), power_type'(250 - 7 * p),
                   p == spa_pkg::MAX_TERMS + 1);
      for (p = 0; p < spa_pkg::MAX_TERMS + 3; p++)
         push_term(1'b1, rand_coeff(), power_type'(252 - 7 * p),
                   p == spa_pkg::MAX_TERMS + 2);
      wait_drained();

      // random pairs under each idling pattern, the first with a long hold-off
      run_phase(0,  0,  48, 1'b1);
      run_phase(83, 0,  48, 1'b0);
      run_phase(0,  83, 48, 1'b0);
      run_phase(29, 29, 48, 1'b0);
      run_phase(0,  0,  10, 1'b0);

      while (pending_terms.size() != 0 || req_ch.valid || due_terms.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);

      if (error_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
